### sv/smm_pkg.sv
// Shared types and constants for the set min/max/median unit.
`default_nettype none
package smm_pkg;
	localparam int STORE_DEPTH = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int CNT_W = $clog2(STORE_DEPTH + 1);
	localparam int IDX_W = $clog2(STORE_DEPTH);
	localparam int MED_W = SAMPLE_BITS + 1;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [MED_W-1:0] med_t;
	typedef logic [CNT_W-1:0] count_t;

	// per-cycle command broadcast to every cell of the chain
	typedef struct packed {
		logic ins;    // insert the incoming sample in sorted position
		logic drain;  // shift every cell one place toward the head
	} cell_ctrl_t;
endpackage
`default_nettype wire

### sv/smm_cell.sv
// One cell of the sorted insertion chain.
`default_nettype none
module smm_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  smm_pkg::cell_ctrl_t ctrl,
	input  smm_pkg::sample_t    sample,
	input  smm_pkg::sample_t    prev_val,
	input  wire                 prev_valid,
	input  wire                 prev_gt,
	input  smm_pkg::sample_t    next_val,
	input  wire                 next_valid,
	output smm_pkg::sample_t    val,
	output logic                valid,
	output logic                gt
);
	import smm_pkg::*;

	sample_t val_q;
	logic    valid_q;

	// this cell holds a value strictly above the incoming word
	assign gt = valid_q && (val_q > sample);

	// value: shift up on insert, shift down on drain
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (prev_gt) begin
				val_q <= prev_val;
			end else if (prev_valid && (gt || !valid_q)) begin
				val_q <= sample;
			end
		end else if (ctrl.drain) begin
			val_q <= next_val;
		end
	end

	// occupancy: grows from the head, empties as the chain drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.ins) begin
			valid_q <= valid_q | prev_valid;
		end else if (ctrl.drain) begin
			valid_q <= next_valid;
		end
	end

	assign val   = val_q;
	assign valid = valid_q;
endmodule
`default_nettype wire

### sv/smm_ctrl.sv
// Fill count, drain sequencing and result capture for the sorted chain.
`default_nettype none
module smm_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  sample_valid,
	output logic                 sample_stall,
	input  wire                  last_item,
	input  smm_pkg::sample_t     head_val,
	output smm_pkg::cell_ctrl_t  ctrl,
	output logic                 result_valid,
	input  wire                  result_stall,
	output smm_pkg::sample_t     smallest,
	output smm_pkg::sample_t     largest,
	output smm_pkg::med_t        median_doubled,
	output smm_pkg::count_t      sample_count,
	output logic                 overflowed
);
	import smm_pkg::*;

	count_t          fill_q;
	logic            ovf_q;
	logic            drain_q;
	logic [IDX_W-1:0] cnt_q;
	sample_t         min_q;
	med_t            med_q;
	logic            out_valid_q;

	logic   accept;
	logic   full;
	logic   final_step;
	logic   out_busy;
	logic   step;
	count_t half;
	count_t cnt_ext;
	logic   hit_lo;
	logic   hit_mid;
	med_t   head_ext;
	med_t   med_next;

	assign accept     = sample_valid && !drain_q;
	assign full       = (fill_q == CNT_W'(STORE_DEPTH));
	assign cnt_ext    = CNT_W'(cnt_q);
	assign final_step = drain_q && (cnt_ext == fill_q - 1'b1);
	assign out_busy   = out_valid_q && result_stall;
	assign step       = drain_q && !(final_step && out_busy);

	assign ctrl.ins   = accept && !full;
	assign ctrl.drain = step;
	assign sample_stall = drain_q;

	// median pick-up as the sorted words pass the head cell
	assign half     = fill_q >> 1;
	assign hit_lo   = !fill_q[0] && (cnt_ext == half - 1'b1);
	assign hit_mid  = (cnt_ext == half);
	assign head_ext = MED_W'(head_val);

	always_comb begin
		med_next = med_q;
		if (hit_mid) begin
			if (fill_q[0]) begin
				med_next = head_ext <<< 1;
			end else begin
				med_next = med_q + head_ext;
			end
		end else if (hit_lo) begin
			med_next = head_ext;
		end
	end

	// set bookkeeping and drain sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			ovf_q   <= 1'b0;
			drain_q <= 1'b0;
			cnt_q   <= '0;
		end else if (accept) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				fill_q <= fill_q + 1'b1;
			end
			if (last_item) begin
				drain_q <= 1'b1;
				cnt_q   <= '0;
			end
		end else if (step) begin
			if (final_step) begin
				fill_q  <= '0;
				ovf_q   <= 1'b0;
				drain_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// partial results while draining
	always_ff @(posedge clk) begin
		if (step) begin
			if (cnt_q == '0) begin
				min_q <= head_val;
			end
			med_q <= med_next;
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (step && final_step) begin
			smallest       <= (cnt_q == '0) ? head_val : min_q;
			largest        <= head_val;
			median_doubled <= med_next;
			sample_count   <= fill_q;
			overflowed     <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && final_step) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> (fill_q != '0))
		else $error("drain with empty chain");

	a_cnt_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> (cnt_ext < fill_q))
		else $error("drain index past fill count");

	a_result_after_drain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(drain_q))
		else $error("result without drain");

	a_insert_counts: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ins |=> (fill_q == CNT_W'($past(fill_q) + 1'b1)))
		else $error("insert did not advance fill count");
endmodule
`default_nettype wire

### sv/set_min_max_median_unit.sv
// Top level: min, max and doubled median of a set of signed samples.
// Throughput: one sample per cycle while a set is filling.
// Closing word accepted, then one drain step per kept sample (1..64) as the sorted
// chain shifts past its head cell; result valid the cycle after the final step.
// Input stalls during the drain; the final drain step waits on a held result.
// Reset clears all occupancy, counts and valid flags; sample storage is not reset.
`default_nettype none
module set_min_max_median_unit (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               sample_valid,
	output logic              sample_stall,
	input  smm_pkg::sample_t  sample,
	input  wire               last_item,
	output logic              result_valid,
	input  wire               result_stall,
	output smm_pkg::sample_t  smallest,
	output smm_pkg::sample_t  largest,
	output smm_pkg::med_t     median_doubled,
	output smm_pkg::count_t   sample_count,
	output logic              overflowed
);
	import smm_pkg::*;

	cell_ctrl_t ctrl;
	sample_t    val_w   [STORE_DEPTH];
	logic       valid_w [STORE_DEPTH];
	logic       gt_w    [STORE_DEPTH];

	// sorted insertion chain, head cell holds the smallest word
	for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
		sample_t p_val;
		logic    p_valid;
		logic    p_gt;
		sample_t n_val;
		logic    n_valid;

		if (i == 0) begin : g_head
			assign p_val   = '0;
			assign p_valid = 1'b1;
			assign p_gt    = 1'b0;
		end else begin : g_mid
			assign p_val   = val_w[i-1];
			assign p_valid = valid_w[i-1];
			assign p_gt    = gt_w[i-1];
		end

		if (i == STORE_DEPTH - 1) begin : g_tail
			assign n_val   = '0;
			assign n_valid = 1'b0;
		end else begin : g_body
			assign n_val   = val_w[i+1];
			assign n_valid = valid_w[i+1];
		end

		smm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.sample     (sample),
			.prev_val   (p_val),
			.prev_valid (p_valid),
			.prev_gt    (p_gt),
			.next_val   (n_val),
			.next_valid (n_valid),
			.val        (val_w[i]),
			.valid      (valid_w[i]),
			.gt         (gt_w[i])
		);
	end

	// sequencing and result capture
	smm_ctrl u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.last_item      (last_item),
		.head_val       (val_w[0]),
		.ctrl           (ctrl),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.smallest       (smallest),
		.largest        (largest),
		.median_doubled (median_doubled),
		.sample_count   (sample_count),
		.overflowed     (overflowed)
	);
endmodule
`default_nettype wire
